/* rtl/core/tagged_record_store_core_defines.svh */
// ----------------------------------------------------------------------------
// tagged record store core defines
// assertion macros for the file that checks the record store
// ----------------------------------------------------------------------------
`ifndef TAGGED_RECORD_STORE_CORE_DEFINES_SVH
`define TAGGED_RECORD_STORE_CORE_DEFINES_SVH

// same-cycle implication
`define TRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trs: same-cycle check failed");

// next-cycle implication
`define TRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trs: next-cycle check failed");

`endif

/* rtl/core/trs_pkg.sv */
// ----------------------------------------------------------------------------
// trs_pkg
// types, codes and helpers of the tagged record store
// ----------------------------------------------------------------------------
package trs_pkg;

  localparam int ENTRIES_DEF   = 16;
  localparam int MAX_BYTES_DEF = 64;

  localparam int TAG_W    = 32;
  localparam int LEN_W    = 7;
  localparam int WIDX_W   = 3;
  localparam int WORD_W   = 64;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;
  localparam int STAGE_DEPTH = 8;

  // slave tdata layout
  localparam int S_TAG_LO   = 0;
  localparam int S_DSIZE_LO = S_TAG_LO + TAG_W;
  localparam int S_BSIZE_LO = S_DSIZE_LO + LEN_W;
  localparam int S_WIDX_LO  = S_BSIZE_LO + LEN_W;
  localparam int S_WORD_LO  = S_WIDX_LO + WIDX_W;
  localparam int S_USED_W   = S_WORD_LO + WORD_W;
  localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

  // master tdata layout
  localparam int M_LEN_LO   = 0;
  localparam int M_IDX_LO   = M_LEN_LO + LEN_W;
  localparam int M_WORD_LO  = M_IDX_LO + WIDX_W;
  localparam int M_USED_W   = M_WORD_LO + WORD_W;
  localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

  localparam logic [REQ_W-1:0] REQ_GET    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SMALL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 3'd4;

  typedef struct packed {
    logic                capture;
    logic                scan_clear;
    logic                scan_step;
    logic                tag_write;
    logic                valid_clear;
    logic                word_clear;
    logic                word_next;
    logic                val_write;
    logic                out_load;
    logic                out_word_mode;
    logic [STATUS_W-1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] in_req;
    logic             in_last;
    logic             in_bad_size;
    logic [REQ_W-1:0] req;
    logic             hit;
    logic             free;
    logic             len_small;
    logic             scan_done;
    logic             commit_last;
    logic             out_last;
  } sts_t;

  // bytes below len within word k
  function automatic logic [WORD_W-1:0] byte_mask(input logic [LEN_W-1:0] len,
                                                   input logic [WIDX_W-1:0] k);
    logic [WORD_W-1:0] m;
    logic [7:0]        pos;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      pos = {2'b00, k, 3'b000} + 8'(b);
      if ({1'b0, len} > pos) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

/* rtl/core/trs_ram.sv */
// ----------------------------------------------------------------------------
// trs_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module trs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/trs_dp.sv */
// ----------------------------------------------------------------------------
// trs_dp
// record store datapath: request latch, staging words, tag scan, rams, output
// ----------------------------------------------------------------------------
module trs_dp #(
  parameter int ENTRIES   = trs_pkg::ENTRIES_DEF,
  parameter int MAX_BYTES = trs_pkg::MAX_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  trs_pkg::cmd_t                  cmd,
  output trs_pkg::sts_t                  sts,
  input  logic [trs_pkg::REQ_W-1:0]      in_req_type,
  input  logic [trs_pkg::TAG_W-1:0]      in_tag,
  input  logic [trs_pkg::LEN_W-1:0]      in_rec_bytes,
  input  logic [trs_pkg::LEN_W-1:0]      in_room_bytes,
  input  logic [trs_pkg::WIDX_W-1:0]     in_word_index,
  input  logic [trs_pkg::WORD_W-1:0]     in_value_word,
  input  logic                           in_last_word,
  output logic [trs_pkg::STATUS_W-1:0]   status,
  output logic [trs_pkg::LEN_W-1:0]      length,
  output logic [trs_pkg::WIDX_W-1:0]     out_index,
  output logic [trs_pkg::WORD_W-1:0]     out_word,
  output logic                           last
);

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int VAW  = $clog2(ENTRIES * 8);
  localparam int WPE  = (MAX_BYTES + 7) / 8;
  localparam int TRW  = trs_pkg::TAG_W + trs_pkg::LEN_W;

  // latched request
  logic [trs_pkg::REQ_W-1:0]  req_type;
  logic [trs_pkg::TAG_W-1:0]  req_tag;
  logic [trs_pkg::LEN_W-1:0]  req_dsize;
  logic [trs_pkg::LEN_W-1:0]  req_bsize;
  logic [trs_pkg::WORD_W-1:0] staging [trs_pkg::STAGE_DEPTH];

  logic [ENTRIES-1:0]         valid;
  logic [CW-1:0]              scan_cnt;
  logic                       pend;
  logic [IW-1:0]              idx_d;
  logic                       hit;
  logic                       free;
  logic [IW-1:0]              slot_hit;
  logic [IW-1:0]              slot_free;
  logic [trs_pkg::LEN_W-1:0]  hit_len;
  logic [trs_pkg::WIDX_W-1:0] wk;

  logic [IW-1:0]              slot_sel;
  logic [TRW-1:0]             tag_rdata;
  logic [trs_pkg::TAG_W-1:0]  rd_tag;
  logic [trs_pkg::LEN_W-1:0]  rd_len;
  logic [VAW-1:0]             val_addr;
  logic [trs_pkg::WORD_W-1:0] val_rdata;
  logic [3:0]                 nwords;
  logic                       word_last;
  logic                       entry_hit;

  assign slot_sel  = hit ? slot_hit : slot_free;
  assign rd_tag    = tag_rdata[TRW-1 -: trs_pkg::TAG_W];
  assign rd_len    = tag_rdata[trs_pkg::LEN_W-1:0];
  assign val_addr  = VAW'({slot_sel, wk});
  assign nwords    = 4'((8'(hit_len) + 8'd7) >> 3);
  assign word_last = ((4'(wk) + 4'd1) == nwords);
  assign entry_hit = valid[idx_d] && (rd_tag == req_tag);

  trs_ram #(
    .WIDTH (TRW),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (cmd.tag_write),
    .waddr (slot_sel),
    .wdata ({req_tag, req_dsize}),
    .raddr (scan_cnt[IW-1:0]),
    .rdata (tag_rdata)
  );

  trs_ram #(
    .WIDTH (trs_pkg::WORD_W),
    .DEPTH (ENTRIES * 8)
  ) u_val_ram (
    .clk   (clk),
    .we    (cmd.val_write),
    .waddr (val_addr),
    .wdata (staging[wk] & trs_pkg::byte_mask(req_dsize, wk)),
    .raddr (val_addr),
    .rdata (val_rdata)
  );

  // request latch and staging
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type  <= in_req_type;
      req_tag   <= in_tag;
      req_dsize <= in_rec_bytes;
      req_bsize <= in_room_bytes;
      if (in_req_type == trs_pkg::REQ_STORE) begin
        staging[in_word_index] <= in_value_word;
      end
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.tag_write) begin
      valid[slot_sel] <= 1'b1;
    end else if (cmd.valid_clear) begin
      valid[slot_hit] <= 1'b0;
    end
  end

  // tag scan: one address issued per cycle, compared in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      pend     <= 1'b0;
      hit      <= 1'b0;
      free     <= 1'b0;
    end else if (cmd.scan_clear) begin
      scan_cnt <= '0;
      pend     <= 1'b0;
      hit      <= 1'b0;
      free     <= 1'b0;
    end else if (cmd.scan_step) begin
      if (scan_cnt != CW'(ENTRIES)) begin
        pend     <= 1'b1;
        idx_d    <= scan_cnt[IW-1:0];
        scan_cnt <= scan_cnt + CW'(1);
      end else begin
        pend <= 1'b0;
      end
      if (pend) begin
        if (entry_hit && !hit) begin
          hit      <= 1'b1;
          slot_hit <= idx_d;
          hit_len  <= rd_len;
        end
        if (!valid[idx_d] && !free) begin
          free      <= 1'b1;
          slot_free <= idx_d;
        end
      end
    end
  end

  // word counter
  always_ff @(posedge clk) begin
    if (cmd.word_clear) begin
      wk <= '0;
    end else if (cmd.word_next) begin
      wk <= wk + trs_pkg::WIDX_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_word_mode) begin
        status    <= trs_pkg::ST_OK;
        length    <= hit_len;
        out_index <= wk;
        out_word  <= val_rdata & trs_pkg::byte_mask(hit_len, wk);
        last      <= word_last;
      end else begin
        status    <= cmd.out_status;
        length    <= '0;
        out_index <= '0;
        out_word  <= '0;
        last      <= 1'b1;
      end
    end
  end

  always_comb begin
    sts             = '0;
    sts.in_req      = in_req_type;
    sts.in_last     = in_last_word;
    sts.in_bad_size = (in_rec_bytes == '0) ||
                      (in_rec_bytes > trs_pkg::LEN_W'(MAX_BYTES));
    sts.req         = req_type;
    sts.hit         = hit;
    sts.free        = free;
    sts.len_small   = (req_bsize < hit_len);
    sts.scan_done   = (scan_cnt == CW'(ENTRIES)) && !pend;
    sts.commit_last = (wk == trs_pkg::WIDX_W'(WPE - 1));
    sts.out_last    = last;
  end

endmodule

/* rtl/core/trs_ctrl.sv */
// ----------------------------------------------------------------------------
// trs_ctrl
// request sequencer: scan, decide, commit or stream, hand off result beats
// ----------------------------------------------------------------------------
module trs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  trs_pkg::sts_t sts,
  output trs_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    DECIDE,
    COMMIT,
    RD_WAIT,
    RD_LOAD,
    OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          case (sts.in_req)
            trs_pkg::REQ_GET, trs_pkg::REQ_DELETE: begin
              cmd.scan_clear = 1'b1;
              state_next     = SCAN;
            end
            trs_pkg::REQ_STORE: begin
              if (sts.in_last) begin
                if (sts.in_bad_size) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_status = trs_pkg::ST_BAD_SIZE;
                  state_next     = OUT;
                end else begin
                  cmd.scan_clear = 1'b1;
                  state_next     = SCAN;
                end
              end
            end
            default: begin
              state_next = IDLE;
            end
          endcase
        end
      end
      SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = DECIDE;
        end
      end
      DECIDE: begin
        case (sts.req)
          trs_pkg::REQ_GET: begin
            if (!sts.hit) begin
              cmd.out_load   = 1'b1;
              cmd.out_status = trs_pkg::ST_MISS;
              state_next     = OUT;
            end else if (sts.len_small) begin
              cmd.out_load   = 1'b1;
              cmd.out_status = trs_pkg::ST_SMALL;
              state_next     = OUT;
            end else begin
              cmd.word_clear = 1'b1;
              state_next     = RD_WAIT;
            end
          end
          trs_pkg::REQ_STORE: begin
            if (sts.hit || sts.free) begin
              cmd.tag_write  = 1'b1;
              cmd.word_clear = 1'b1;
              state_next     = COMMIT;
            end else begin
              cmd.out_load   = 1'b1;
              cmd.out_status = trs_pkg::ST_FULL;
              state_next     = OUT;
            end
          end
          trs_pkg::REQ_DELETE: begin
            cmd.out_load = 1'b1;
            if (sts.hit) begin
              cmd.valid_clear = 1'b1;
              cmd.out_status  = trs_pkg::ST_OK;
            end else begin
              cmd.out_status = trs_pkg::ST_MISS;
            end
            state_next = OUT;
          end
          default: begin
            state_next = IDLE;
          end
        endcase
      end
      COMMIT: begin
        cmd.val_write = 1'b1;
        if (sts.commit_last) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = trs_pkg::ST_OK;
          state_next     = OUT;
        end else begin
          cmd.word_next = 1'b1;
        end
      end
      RD_WAIT: begin
        state_next = RD_LOAD;
      end
      RD_LOAD: begin
        cmd.out_load      = 1'b1;
        cmd.out_word_mode = 1'b1;
        state_next        = OUT;
      end
      OUT: begin
        if (m_tready) begin
          if (sts.out_last) begin
            state_next = IDLE;
          end else begin
            cmd.word_next = 1'b1;
            state_next    = RD_WAIT;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= (state_next == OUT);
    end
  end

endmodule

/* rtl/core/tagged_record_store_core.sv */
// ----------------------------------------------------------------------------
// tagged_record_store_core
// fixed table of tagged records with get, store and delete requests
// ----------------------------------------------------------------------------
// Holds ENTRIES records, each a 32-bit tag, a byte length and up to MAX_BYTES
// value bytes kept as little-endian 64-bit words. A store sends its value
// words one beat at a time into an eight-word staging buffer; the beat with
// tlast set commits the record to the entry holding the same tag, else to the
// first empty entry, with bytes beyond the length zeroed. A get returns one
// result beat per value word, a delete empties the entry; every other outcome
// (miss, buffer too small, table full, bad size) is one result beat. One
// request is in flight at a time. A store word that does not commit is taken
// while the block stays idle, an unused request code is dropped, and a commit
// with a bad size has its result beat ready in the cycle after the request
// beat. A get, a delete or a commit with a valid size first walks the tag
// ram, one entry per cycle, then passes through a decision state; a commit
// then writes (MAX_BYTES + 7) / 8 words, one per cycle on the single value
// ram port, and a get hit takes each returned word through a ram read, a load
// and a hand-off, reading the next word only after the hand-off is accepted.
// The table starts empty after reset with no clearing pass: per-entry valid
// bits are cleared at once.
// ----------------------------------------------------------------------------
`include "tagged_record_store_core_defines.svh"

module tagged_record_store_core #(
  parameter int ENTRIES   = trs_pkg::ENTRIES_DEF,   // 1 to 256
  parameter int MAX_BYTES = trs_pkg::MAX_BYTES_DEF  // 8 to 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // request beats
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tag, record bytes, room bytes, word_index, value_word, zero fill
  input  logic [trs_pkg::S_TDATA_W-1:0]   s_tdata,
  // req_type
  input  logic [trs_pkg::REQ_W-1:0]       s_tuser,
  // last_word
  input  logic                            s_tlast,
  // result beats
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // length, out_index, out_word, zero fill
  output logic [trs_pkg::M_TDATA_W-1:0]   m_tdata,
  // status
  output logic [trs_pkg::STATUS_W-1:0]    m_tuser,
  // last
  output logic                            m_tlast
);

  trs_pkg::cmd_t cmd;
  trs_pkg::sts_t sts;

  logic [trs_pkg::LEN_W-1:0]  out_length;
  logic [trs_pkg::WIDX_W-1:0] out_index;
  logic [trs_pkg::WORD_W-1:0] out_word;

  // sequencer: owns the handshakes, issues commands to the datapath
  trs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: request fields unpacked from the slave beat
  trs_dp #(
    .ENTRIES   (ENTRIES),
    .MAX_BYTES (MAX_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (s_tuser),
    .in_tag         (s_tdata[trs_pkg::S_TAG_LO +: trs_pkg::TAG_W]),
    .in_rec_bytes   (s_tdata[trs_pkg::S_DSIZE_LO +: trs_pkg::LEN_W]),
    .in_room_bytes  (s_tdata[trs_pkg::S_BSIZE_LO +: trs_pkg::LEN_W]),
    .in_word_index  (s_tdata[trs_pkg::S_WIDX_LO +: trs_pkg::WIDX_W]),
    .in_value_word  (s_tdata[trs_pkg::S_WORD_LO +: trs_pkg::WORD_W]),
    .in_last_word   (s_tlast),
    .status         (m_tuser),
    .length         (out_length),
    .out_index      (out_index),
    .out_word       (out_word),
    .last           (m_tlast)
  );

  // result beat packing, zero fill on top
  assign m_tdata = trs_pkg::M_TDATA_W'({out_word, out_index, out_length});

  // no request is taken while a result beat is pending
  `TRS_ASSERT_IMPL(a_no_accept_busy, clk, rst, s_tvalid && s_tready, !m_tvalid)
  // every non-ok result is a single closing beat without length
  `TRS_ASSERT_IMPL(a_err_single, clk, rst, m_tvalid && (m_tuser != trs_pkg::ST_OK), m_tlast && (out_length == '0))
  // reported length never exceeds the record capacity
  `TRS_ASSERT_IMPL(a_len_range, clk, rst, m_tvalid, out_length <= trs_pkg::LEN_W'(MAX_BYTES))
  // the block is ready again right after its closing beat is taken
  `TRS_ASSERT_NEXT(a_ready_after_last, clk, rst, m_tvalid && m_tready && m_tlast, s_tready)

endmodule
